[hdl/dbom_pkg.sv]
// Shared constants and controller/datapath interface types for the box overlap matcher.
package dbom_pkg;

  // Input command codes
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_TEST   = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  // Result kinds
  localparam logic KIND_MATCH  = 1'b0;
  localparam logic KIND_TOTALS = 1'b1;

  // Configuration register indexes
  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_MISSES    = 1'b1;

  localparam int THR_W       = 17;
  localparam int THR_RESET   = 32768;
  localparam int CMD_W       = 2;
  localparam int SLOT_OUT_W  = 6;
  localparam int COUNT_W     = 16;
  localparam int FN_W        = 7;
  localparam int FRAC_BITS   = 16;
  localparam int OUT_TDATA_W = 48;

  typedef struct packed {
    logic load;    // write a ground-truth box
    logic start;   // latch a detection and rewind the walk
    logic issue;   // read the next table slot into the pipeline
    logic emit;    // commit the result and load the output register
    logic finish;  // the pending result is an image totals report
  } ctrl_cmd_t;

  typedef struct packed {
    logic found;       // a slot passed the overlap test
    logic all_issued;  // every slot has been read
    logic pipe_empty;  // no slot still in the compare pipeline
    logic out_free;    // output register can take a result this cycle
  } dp_status_t;

endpackage

[hdl/dbom_ctrl.sv]
// Controller state machine: accepts commands, sequences the table walk and result commit.
module dbom_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_valid,
  input  logic [dbom_pkg::CMD_W-1:0]    command,
  output logic                          s_ready,
  input  dbom_pkg::dp_status_t          status,
  output dbom_pkg::ctrl_cmd_t           cmd
);
  import dbom_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   finish_pending;
  logic   accept;

  assign s_ready = (state == ST_IDLE);
  assign accept  = s_valid && s_ready;

  always_comb begin
    cmd.load   = accept && (command == CMD_LOAD);
    cmd.start  = accept && (command == CMD_TEST);
    cmd.issue  = (state == ST_WALK) && !status.found && !status.all_issued;
    cmd.emit   = (state == ST_EMIT) && status.out_free;
    cmd.finish = finish_pending;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (command)
            CMD_TEST:   state_next = ST_WALK;
            CMD_FINISH: state_next = ST_EMIT;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_WALK: begin
        if (status.found || (status.all_issued && status.pipe_empty)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      finish_pending <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        finish_pending <= (command == CMD_FINISH);
      end
    end
  end

endmodule

[hdl/dbom_datapath.sv]
// Datapath: box table, overlap compare pipeline, counters and output register.
module dbom_datapath #(
  parameter int TABLE_DEPTH = 64,
  parameter int COORD_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dbom_pkg::ctrl_cmd_t                  cmd,
  output dbom_pkg::dp_status_t                 status,
  input  logic [4*COORD_BITS-1:0]              in_box,
  input  logic [dbom_pkg::THR_W-1:0]           threshold,
  input  logic                                 count_misses,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_kind,
  output logic                                 out_matched,
  output logic [dbom_pkg::SLOT_OUT_W-1:0]      out_slot,
  output logic [dbom_pkg::COUNT_W-1:0]         out_tp,
  output logic [dbom_pkg::COUNT_W-1:0]         out_fp,
  output logic [dbom_pkg::FN_W-1:0]            out_fn,
  output logic                                 out_overflow
);
  import dbom_pkg::*;

  localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int BOX_W  = 4 * COORD_BITS;
  localparam int XW     = COORD_BITS + 2;
  localparam int SPAN_W = COORD_BITS + 1;
  localparam int AREA_W = 2 * SPAN_W;
  localparam int PP_W   = SPAN_W + THR_W;
  localparam int RHS_W  = AREA_W + THR_W;

  // Table storage; a slot is live when below load_pointer and its live bit is set
  logic [BOX_W-1:0] box_mem  [TABLE_DEPTH];
  logic             live_mem [TABLE_DEPTH];

  logic [CNT_W-1:0]   load_pointer;
  logic [CNT_W-1:0]   live_count;
  logic [SLOT_W-1:0]  search_start;
  logic [COUNT_W-1:0] hit_count;
  logic [COUNT_W-1:0] miss_count;
  logic               overflow_seen;

  logic               table_full;
  logic [SLOT_W-1:0]  load_idx;

  // Walk state
  logic [SLOT_W-1:0]  ptr;
  logic [CNT_W-1:0]   issue_cnt;
  logic               found;
  logic [SLOT_W-1:0]  found_slot;

  logic signed [COORD_BITS-1:0] dl, dt, dr, db;

  // Stage A: table read
  logic               a_valid;
  logic [SLOT_W-1:0]  a_slot;
  logic               a_in_range;
  logic [BOX_W-1:0]   a_box;
  logic               a_live;
  // Stage B: axis spans
  logic               b_valid;
  logic [SLOT_W-1:0]  b_slot;
  logic [SPAN_W-1:0]  b_iw, b_ih, b_uw, b_uh;
  // Stage C: areas
  logic               c_valid;
  logic [SLOT_W-1:0]  c_slot;
  logic [AREA_W-1:0]  c_inter, c_uni;
  // Stage D: threshold partial products
  logic               d_valid;
  logic [SLOT_W-1:0]  d_slot;
  logic [AREA_W-1:0]  d_inter;
  logic [PP_W-1:0]    d_plo, d_phi;
  // Stage E: compare
  logic               e_valid;
  logic [SLOT_W-1:0]  e_slot;
  logic               e_pass;

  logic               hit_now;

  logic signed [COORD_BITS-1:0] gl, gt, gr, gb;
  logic signed [COORD_BITS-1:0] il, ir, it, ib, ul, ur, ut, ub;
  logic signed [XW-1:0]         w_iw, w_ih, w_uw, w_uh;
  logic [RHS_W-1:0]             rhs, lhs;

  logic [COUNT_W-1:0]      hit_count_next, miss_count_next;
  logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;
  logic [CNT_W+FN_W-1:0]   live_ext;
  logic [FN_W-1:0]         fn_sat;

  assign table_full = (load_pointer == CNT_W'(TABLE_DEPTH));
  assign load_idx   = load_pointer[SLOT_W-1:0];
  assign hit_now    = e_valid && e_pass;

  always_comb begin
    status.found      = found;
    status.all_issued = (issue_cnt == CNT_W'(TABLE_DEPTH));
    status.pipe_empty = !(a_valid || b_valid || c_valid || d_valid || e_valid);
    status.out_free   = !out_valid || out_ready;
  end

  // Box memory: one write port for loads, one read port for the walk
  always_ff @(posedge clk) begin
    if (cmd.load && !table_full) begin
      box_mem[load_idx] <= in_box;
    end
    if (cmd.issue) begin
      a_box <= box_mem[ptr];
    end
  end

  // Live bits: set on load, dropped on a match
  always_ff @(posedge clk) begin
    if (cmd.load && !table_full) begin
      live_mem[load_idx] <= 1'b1;
    end else if (cmd.emit && !cmd.finish && found) begin
      live_mem[found_slot] <= 1'b0;
    end
    if (cmd.issue) begin
      a_live <= live_mem[ptr];
    end
  end

  // Span and overlap geometry
  always_comb begin
    gl = a_box[0*COORD_BITS +: COORD_BITS];
    gt = a_box[1*COORD_BITS +: COORD_BITS];
    gr = a_box[2*COORD_BITS +: COORD_BITS];
    gb = a_box[3*COORD_BITS +: COORD_BITS];
    il = (dl > gl) ? dl : gl;
    ir = (dr < gr) ? dr : gr;
    it = (dt > gt) ? dt : gt;
    ib = (db < gb) ? db : gb;
    ul = (dl < gl) ? dl : gl;
    ur = (dr > gr) ? dr : gr;
    ut = (dt < gt) ? dt : gt;
    ub = (db > gb) ? db : gb;
    w_iw = XW'(ir) - XW'(il) + XW'(1);
    w_ih = XW'(ib) - XW'(it) + XW'(1);
    w_uw = XW'(ur) - XW'(ul) + XW'(1);
    w_uh = XW'(ub) - XW'(ut) + XW'(1);
  end

  assign rhs = (RHS_W'(d_phi) << SPAN_W) + RHS_W'(d_plo);
  assign lhs = RHS_W'({d_inter, {FRAC_BITS{1'b0}}});

  // Compare pipeline payload
  always_ff @(posedge clk) begin
    a_slot     <= ptr;
    a_in_range <= (CNT_W'(ptr) < load_pointer);

    b_slot <= a_slot;
    b_iw   <= (w_iw[XW-1] || (w_iw == '0)) ? '0 : w_iw[SPAN_W-1:0];
    b_ih   <= (w_ih[XW-1] || (w_ih == '0)) ? '0 : w_ih[SPAN_W-1:0];
    b_uw   <= (w_uw[XW-1] || (w_uw == '0)) ? '0 : w_uw[SPAN_W-1:0];
    b_uh   <= (w_uh[XW-1] || (w_uh == '0)) ? '0 : w_uh[SPAN_W-1:0];

    c_slot  <= b_slot;
    c_inter <= b_iw * b_ih;
    c_uni   <= b_uw * b_uh;

    d_slot  <= c_slot;
    d_inter <= c_inter;
    d_plo   <= c_uni[SPAN_W-1:0] * threshold;
    d_phi   <= c_uni[AREA_W-1:SPAN_W] * threshold;

    e_slot <= d_slot;
    e_pass <= (lhs > rhs);

    if (cmd.start) begin
      dl <= in_box[0*COORD_BITS +: COORD_BITS];
      dt <= in_box[1*COORD_BITS +: COORD_BITS];
      dr <= in_box[2*COORD_BITS +: COORD_BITS];
      db <= in_box[3*COORD_BITS +: COORD_BITS];
    end
    if (hit_now && !found) begin
      found_slot <= e_slot;
    end
  end

  // Pipeline valids and walk control; flush everything behind the first hit
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      e_valid   <= 1'b0;
      found     <= 1'b0;
      ptr       <= '0;
      issue_cnt <= CNT_W'(TABLE_DEPTH);
    end else if (cmd.start) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      e_valid   <= 1'b0;
      found     <= 1'b0;
      ptr       <= search_start;
      issue_cnt <= '0;
    end else if (hit_now) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
      found   <= 1'b1;
    end else begin
      a_valid <= cmd.issue;
      b_valid <= a_valid && a_in_range && a_live;
      c_valid <= b_valid;
      d_valid <= c_valid;
      e_valid <= d_valid;
      if (cmd.issue) begin
        ptr       <= (ptr == SLOT_W'(TABLE_DEPTH - 1)) ? '0 : ptr + SLOT_W'(1);
        issue_cnt <= issue_cnt + CNT_W'(1);
      end
    end
  end

  // Result values
  always_comb begin
    hit_count_next  = hit_count;
    miss_count_next = miss_count;
    if (!cmd.finish) begin
      if (found) begin
        if (hit_count != '1) hit_count_next = hit_count + COUNT_W'(1);
      end else if (count_misses && (miss_count != '1)) begin
        miss_count_next = miss_count + COUNT_W'(1);
      end
    end
    slot_ext = {{SLOT_OUT_W{1'b0}}, found_slot};
    live_ext = {{FN_W{1'b0}}, live_count};
    fn_sat   = (live_ext > (CNT_W + FN_W)'(2 ** FN_W - 1)) ? '1 : live_ext[FN_W-1:0];
  end

  // Image state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      load_pointer  <= '0;
      live_count    <= '0;
      search_start  <= '0;
      hit_count     <= '0;
      miss_count    <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (table_full) begin
          overflow_seen <= 1'b1;
        end else begin
          load_pointer <= load_pointer + CNT_W'(1);
          live_count   <= live_count + CNT_W'(1);
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (cmd.finish) begin
          load_pointer  <= '0;
          live_count    <= '0;
          search_start  <= '0;
          hit_count     <= '0;
          miss_count    <= '0;
          overflow_seen <= 1'b0;
        end else begin
          hit_count  <= hit_count_next;
          miss_count <= miss_count_next;
          if (found) begin
            live_count   <= live_count - CNT_W'(1);
            search_start <= (found_slot == SLOT_W'(TABLE_DEPTH - 1)) ?
                            '0 : found_slot + SLOT_W'(1);
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind     <= cmd.finish ? KIND_TOTALS : KIND_MATCH;
      out_matched  <= !cmd.finish && found;
      out_slot     <= (!cmd.finish && found) ? slot_ext[SLOT_OUT_W-1:0] : '0;
      out_tp       <= hit_count_next;
      out_fp       <= miss_count_next;
      out_fn       <= cmd.finish ? fn_sat : '0;
      out_overflow <= overflow_seen;
    end
  end

endmodule

[hdl/detection_box_overlap_matcher.sv]
// A load writes the table directly; a finish goes from idle to the emit state and reports from there.
// A test reads one table slot per cycle through a five-stage overlap compare
// pipeline and reports once the whole table has been walked, sooner on a hit.
// Throughput: one item at a time; the walk over the single table read port sets the rate.
// Reset: rst is synchronous; it empties the table, zeroes all counts and loads
// the threshold with one half and the miss flag with zero. No clearing pass is needed.
module detection_box_overlap_matcher #(
  parameter int TABLE_DEPTH = 64,
  parameter int COORD_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // box_left, box_top, box_right, box_bottom
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_tdata,
  // command
  input  logic [dbom_pkg::CMD_W-1:0]             s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // matched, matched_slot, true_positives, false_positives, false_negatives,
  // table_overflow
  output logic [dbom_pkg::OUT_TDATA_W-1:0]       m_tdata,
  // report_kind
  output logic                                   m_tuser,
  input  logic                                   cfg_we,
  input  logic                                   cfg_index,
  input  logic [dbom_pkg::THR_W-1:0]             cfg_wdata
);
  import dbom_pkg::*;

  logic [THR_W-1:0]      overlap_threshold;
  logic                  count_misses_flag;
  ctrl_cmd_t             cmd;
  dp_status_t            status;

  logic                  out_matched;
  logic [SLOT_OUT_W-1:0] out_slot;
  logic [COUNT_W-1:0]    out_tp;
  logic [COUNT_W-1:0]    out_fp;
  logic [FN_W-1:0]       out_fn;
  logic                  out_overflow;

  always_ff @(posedge clk) begin
    if (rst) begin
      overlap_threshold <= THR_W'(THR_RESET);
      count_misses_flag <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD: overlap_threshold <= cfg_wdata;
        CFG_MISSES:    count_misses_flag <= cfg_wdata[0];
        default:       ;
      endcase
    end
  end

  dbom_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .command (s_tuser),
    .s_ready (s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  dbom_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_box       (s_tdata[4*COORD_BITS-1:0]),
    .threshold    (overlap_threshold),
    .count_misses (count_misses_flag),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_kind     (m_tuser),
    .out_matched  (out_matched),
    .out_slot     (out_slot),
    .out_tp       (out_tp),
    .out_fp       (out_fp),
    .out_fn       (out_fn),
    .out_overflow (out_overflow)
  );

  assign m_tdata = {1'b0, out_overflow, out_fn, out_fp, out_tp, out_slot, out_matched};

  // A hit flushes the compare pipeline before the controller sees it
  assert property (@(posedge clk) disable iff (rst) status.found |-> status.pipe_empty)
    else $error("compare pipeline still busy after a hit");

  // Never overwrite a result that has not been taken
  assert property (@(posedge clk) disable iff (rst) cmd.emit |-> status.out_free)
    else $error("result committed while output register is occupied");

  // No table read past the end of the walk
  assert property (@(posedge clk) disable iff (rst) cmd.issue |-> !status.all_issued)
    else $error("table read issued after the walk completed");

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the detection box overlap matcher.
`timescale 1ns / 1ps

module tb_top;
  import dbom_pkg::*;

  localparam int DEPTH = 64;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]          command;
    logic signed [15:0]  left;
    logic signed [15:0]  top;
    logic signed [15:0]  right;
    logic signed [15:0]  bottom;
  } box_item_t;

  typedef struct {
    bit         kind;
    bit         matched;
    bit [5:0]   slot;
    bit [15:0]  tp;
    bit [15:0]  fp;
    bit [6:0]   fn;
    bit         ovf;
  } report_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [16:0] cfg_wdata = '0;

  detection_box_overlap_matcher u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: ground-truth table, counts and register copies
  box_item_t  gt_box [DEPTH];
  bit         gt_valid [DEPTH];
  int         load_ptr = 0;
  int         scan_from = 0;
  int         hits = 0;
  int         misses = 0;
  bit         ovf_seen = 1'b0;
  bit [16:0]  thr_reg = 17'd32768;
  bit         miss_on = 1'b0;

  box_item_t  box_queue [$];
  report_t    expected_reports [$];
  box_item_t  cur_item;
  int         errors = 0;
  int         queued_items = 0;

  // Idling controls
  int         burst_left = 0;
  int         gap_left = 0;
  int         gap_hi = 4;
  bit         rx_steady = 1'b0;
  logic [15:0] rx_pat = 16'h5a3c;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8ms;
    $display("tb_top failed");
    $finish;
  end

  function automatic longint unsigned axis_len(longint lo, longint hi);
    longint d;
    d = hi - lo + 1;
    return (d > 0) ? longint'(d) : 0;
  endfunction

  // Intersection area * 2^16 against threshold * bounding-box area
  function automatic bit overlap_passes(box_item_t d, box_item_t g);
    longint dl, dt, dr, db, gl, gt, gr, gb;
    longint unsigned common, bound, lhs, rhs;
    dl = d.left;  dt = d.top;  dr = d.right;  db = d.bottom;
    gl = g.left;  gt = g.top;  gr = g.right;  gb = g.bottom;
    common = axis_len((dl > gl) ? dl : gl, (dr < gr) ? dr : gr) *
             axis_len((dt > gt) ? dt : gt, (db < gb) ? db : gb);
    bound  = axis_len((dl < gl) ? dl : gl, (dr > gr) ? dr : gr) *
             axis_len((dt < gt) ? dt : gt, (db > gb) ? db : gb);
    lhs = common << 16;
    rhs = bound * 64'(thr_reg);
    return lhs > rhs;
  endfunction

  task automatic predict_report(input box_item_t it);
    report_t rep;
    bit      hit;
    int      slot, s, k, fn;
    rep = '{default: 0};
    hit = 1'b0;
    slot = 0;
    fn = 0;
    case (it.command)
      CMD_LOAD: begin
        if (load_ptr < DEPTH) begin
          gt_box[load_ptr] = it;
          gt_valid[load_ptr] = 1'b1;
          load_ptr++;
        end else begin
          ovf_seen = 1'b1;
        end
      end
      CMD_TEST: begin
        for (k = 0; k < DEPTH && !hit; k++) begin
          s = (scan_from + k) % DEPTH;
          if (gt_valid[s] && overlap_passes(it, gt_box[s])) begin
            hit = 1'b1;
            slot = s;
          end
        end
        if (hit) begin
          gt_valid[slot] = 1'b0;
          scan_from = (slot + 1) % DEPTH;
          if (hits < 65535) hits++;
        end else if (miss_on && misses < 65535) begin
          misses++;
        end
        rep.kind = KIND_MATCH;
        rep.matched = hit;
        rep.slot = 6'(slot);
        rep.tp = 16'(hits);
        rep.fp = 16'(misses);
        rep.ovf = ovf_seen;
        expected_reports.push_back(rep);
      end
      CMD_FINISH: begin
        for (s = 0; s < DEPTH; s++) begin
          if (gt_valid[s]) fn++;
        end
        rep.kind = KIND_TOTALS;
        rep.tp = 16'(hits);
        rep.fp = 16'(misses);
        rep.fn = (fn > 127) ? 7'd127 : 7'(fn);
        rep.ovf = ovf_seen;
        expected_reports.push_back(rep);
        // start a fresh image
        for (s = 0; s < DEPTH; s++) gt_valid[s] = 1'b0;
        load_ptr = 0;
        scan_from = 0;
        hits = 0;
        misses = 0;
        ovf_seen = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
  endtask

  // Sender: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) predict_report(cur_item);
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (box_queue.size() > 0) begin
          cur_item = box_queue.pop_front();
          s_tdata <= {cur_item.bottom, cur_item.right, cur_item.top, cur_item.left};
          s_tuser <= cur_item.command;
          s_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 8);
            if (gap_hi == 0)
              gap_left = 0;
            else if ($urandom_range(0, 9) == 0)
              gap_left = $urandom_range(10, 90);
            else
              gap_left = $urandom_range(0, gap_hi);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall on a rotating pattern, reloaded now and then
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_reports.size() == 0) begin
          flag_mismatch("result with nothing expected", m_tdata, 0);
        end else begin
          report_t want;
          want = expected_reports.pop_front();
          if (m_tuser !== want.kind) flag_mismatch("report_kind", m_tuser, want.kind);
          if (m_tdata[0] !== want.matched) flag_mismatch("matched", m_tdata[0], want.matched);
          if (m_tdata[6:1] !== want.slot) flag_mismatch("matched_slot", m_tdata[6:1], want.slot);
          if (m_tdata[22:7] !== want.tp) flag_mismatch("true_positives", m_tdata[22:7], want.tp);
          if (m_tdata[38:23] !== want.fp)
            flag_mismatch("false_positives", m_tdata[38:23], want.fp);
          if (m_tdata[45:39] !== want.fn)
            flag_mismatch("false_negatives", m_tdata[45:39], want.fn);
          if (m_tdata[46] !== want.ovf) flag_mismatch("table_overflow", m_tdata[46], want.ovf);
        end
      end
      if ($urandom_range(0, 63) == 0)
        rx_pat <= 16'($urandom) | 16'h0101;
      else
        rx_pat <= {rx_pat[0], rx_pat[15:1]};
      m_tready <= rx_steady | rx_pat[0];
    end
  end

  function automatic logic signed [15:0] clip16(int v);
    if (v < -32768) return -16'sd32768;
    if (v > 32767) return 16'sd32767;
    return 16'(v);
  endfunction

  function automatic box_item_t mk(logic [1:0] cmd, int l, int t, int r, int b);
    box_item_t it;
    it.command = cmd;
    it.left = clip16(l);
    it.top = clip16(t);
    it.right = clip16(r);
    it.bottom = clip16(b);
    return it;
  endfunction

  function automatic box_item_t rand_box(logic [1:0] cmd);
    int cx, cy, w, h;
    w = $urandom_range(0, 40);
    h = $urandom_range(0, 40);
    cx = int'($urandom_range(0, 65535)) - 32768;
    cy = int'($urandom_range(0, 65535)) - 32768;
    // push some boxes onto the coordinate limits
    if ($urandom_range(0, 9) == 0) cx = $urandom_range(0, 1) ? -32768 : 32767 - w;
    if ($urandom_range(0, 9) == 0) cy = $urandom_range(0, 1) ? -32768 : 32767 - h;
    return mk(cmd, cx, cy, cx + w, cy + h);
  endfunction

  function automatic box_item_t raw_box(logic [1:0] cmd);
    box_item_t it;
    it.command = cmd;
    it.left = 16'($urandom);
    it.top = 16'($urandom);
    it.right = 16'($urandom);
    it.bottom = 16'($urandom);
    return it;
  endfunction

  task automatic add_item(input box_item_t it);
    box_queue.push_back(it);
    if (it.command != CMD_UNUSED) queued_items++;
  endtask

  // One image: ground-truth loads, detections mixed with late loads and unused commands, then a finish
  task automatic queue_image(input int n_truth, input int n_det);
    box_item_t truth [$];
    box_item_t d, g;
    int        k, mode;
    for (k = 0; k < n_truth; k++) begin
      g = rand_box(CMD_LOAD);
      truth.push_back(g);
      add_item(g);
    end
    for (k = 0; k < n_det; k++) begin
      mode = $urandom_range(0, 99);
      if (mode < 60 && truth.size() > 0) begin
        g = truth[$urandom_range(0, truth.size() - 1)];
        d = mk(CMD_TEST, g.left + int'($urandom_range(0, 4)) - 2,
               g.top + int'($urandom_range(0, 4)) - 2,
               g.right + int'($urandom_range(0, 4)) - 2,
               g.bottom + int'($urandom_range(0, 4)) - 2);
      end else if (mode < 72) begin
        d = rand_box(CMD_TEST);
      end else if (mode < 80) begin
        g = rand_box(CMD_TEST);
        d = mk(CMD_TEST, g.right + 1, g.bottom, g.left, g.top);
      end else if (mode < 88) begin
        d = raw_box(CMD_TEST);
      end else if (mode < 94) begin
        d = rand_box(CMD_LOAD);
      end else if (mode < 97) begin
        d = raw_box(CMD_UNUSED);
      end else begin
        d = raw_box(CMD_LOAD);
      end
      add_item(d);
    end
    add_item(raw_box(CMD_FINISH));
  endtask

  // Wait until every transaction is out and answered, then past the walk latency
  task automatic settle();
    do @(negedge clk);
    while (box_queue.size() != 0 || s_tvalid || expected_reports.size() != 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input bit [16:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_THRESHOLD) thr_reg = val;
    else miss_on = val[0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    bit [16:0] thr_set [6];
    bit        miss_set [6];
    int        p, start_count;

    for (p = 0; p < DEPTH; p++) gt_valid[p] = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, empty table, extremes, inverted boxes, unused command
    add_item(mk(CMD_TEST, -5, -5, 5, 5));
    add_item(mk(CMD_FINISH, 0, 0, 0, 0));
    add_item(mk(CMD_LOAD, -32768, -32768, 32767, 32767));
    add_item(mk(CMD_LOAD, 10, 10, 5, 5));
    add_item(mk(CMD_LOAD, 100, 200, 109, 209));
    add_item(mk(CMD_UNUSED, -1, -1, -1, -1));
    add_item(mk(CMD_TEST, -32768, -32768, 32767, 32767));
    add_item(mk(CMD_TEST, 10, 10, 5, 5));
    add_item(mk(CMD_TEST, 100, 200, 109, 209));
    add_item(mk(CMD_TEST, 100, 200, 109, 209));
    add_item(mk(CMD_LOAD, 100, 200, 109, 209));
    add_item(mk(CMD_TEST, 101, 201, 110, 210));
    add_item(mk(CMD_FINISH, 0, 0, 0, 0));
    settle();

    // Threshold of one: even an identical box misses
    write_reg(CFG_THRESHOLD, 17'd65536);
    write_reg(CFG_MISSES, 17'd1);
    add_item(mk(CMD_LOAD, 0, 0, 3, 3));
    add_item(mk(CMD_TEST, 0, 0, 3, 3));
    add_item(mk(CMD_FINISH, 0, 0, 0, 0));
    settle();

    // Threshold of zero: any shared pixel matches, disjoint boxes do not
    write_reg(CFG_THRESHOLD, 17'd0);
    add_item(mk(CMD_LOAD, 0, 0, 3, 3));
    add_item(mk(CMD_TEST, 4, 4, 8, 8));
    add_item(mk(CMD_TEST, 3, 3, 8, 8));
    add_item(mk(CMD_FINISH, 0, 0, 0, 0));
    settle();

    thr_set[0] = 17'd131071;  miss_set[0] = 1'b0;
    thr_set[1] = 17'd32768;   miss_set[1] = 1'b1;
    thr_set[2] = 17'($urandom_range(0, 65536));  miss_set[2] = 1'b1;
    thr_set[3] = 17'd65535;   miss_set[3] = 1'b0;
    thr_set[4] = 17'd1;       miss_set[4] = 1'b1;
    thr_set[5] = 17'($urandom_range(16384, 52000));
    miss_set[5] = 1'($urandom_range(0, 1));

    for (p = 0; p < 6; p++) begin
      write_reg(CFG_THRESHOLD, thr_set[p]);
      write_reg(CFG_MISSES, {16'd0, miss_set[p]});
      // one phase runs with no idling on either side
      gap_hi = (p == 2) ? 0 : $urandom_range(1, 8);
      rx_steady = (p == 2);
      start_count = queued_items;
      while (queued_items - start_count < 325) begin
        queue_image(($urandom_range(0, 14) == 0) ? $urandom_range(62, 70)
                                                 : $urandom_range(0, 10),
                    $urandom_range(0, 14));
      end
      settle();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

[detection_box_overlap_matcher.f]
hdl/dbom_pkg.sv
hdl/dbom_ctrl.sv
hdl/dbom_datapath.sv
hdl/detection_box_overlap_matcher.sv
sim/tb_top.sv
